>>> hw/rtl/assert_macros.svh
// Assertion macros for the button press monitor RTL.
// Included by the controller, which checks its own control logic; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define BPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Boolean condition must never be true outside reset.
`define BPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/bpm_pkg.sv
// Types and constants for the button press monitor.
// Used by the controller, the datapath and the top level; no dependencies.
package bpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDICATOR_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_STEPS_SHORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_STEPS_LONG  = 3'd5;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic        button_low;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        is_report;
        logic        green_on;
        logic        red_on;
        logic        yellow_on;
        logic        press_done;
        logic [31:0] press_time;
        logic        press_is_short;
        logic [15:0] total_count;
        logic [15:0] short_count;
        logic [15:0] long_count;
        logic [31:0] average_time;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec_sample;
        logic exec_report;
        logic store_avg;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_type;
        logic div_done;
    } ctrl_status_t;

endpackage

>>> hw/rtl/button_press_monitor.sv
// Top level of the button press monitor: debounced press classifier with indicators.
// Depends on bpm_pkg, bpm_ctrl and bpm_datapath.
//
// Usage: each input beat on in_data is either a sample (req_type 0) carrying the
// button level and a millisecond timestamp, or a report request (req_type 1).
// Every input beat produces exactly one result beat on out_data, in order.
// A sample runs the debounce machine, the indicator timeouts, the blink
// sequencer and the press statistics; a report returns the counts and the
// average press duration and then clears the statistics.
// The block works on one item at a time. A sample passes through the
// execute and emit states; a report also waits in the divide state for the
// bit-serial 32-bit divider that forms the average one quotient bit per cycle.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; if the receiver stalls and a second result is ready,
// the block holds it and stops accepting until the output register frees.
// Configuration writes on cfg_* are accepted every cycle and must only occur
// while the block is idle. Reset returns all configuration registers to their
// defaults (50, 500, 1500, 100, 10, 20) and clears the press state and statistics.
module button_press_monitor
    import bpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    bpm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bpm_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/bpm_div.sv
// Iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// Standalone; used by the button press monitor datapath for the average duration.
module bpm_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  count_reg;
    logic [31:0] quot_reg;
    logic [15:0] rem_reg;
    logic [15:0] divisor_reg;

    logic [16:0] shifted;
    logic        fits;
    logic [16:0] diff;

    assign shifted = {rem_reg, quot_reg[31]};
    assign fits    = shifted >= {1'b0, divisor_reg};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so 16 bits hold it between steps.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[30:0], fits};
            rem_reg  <= fits ? diff[15:0] : shifted[15:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hw/rtl/bpm_datapath.sv
// Datapath of the button press monitor: configuration, debounce, indicators,
// statistics, result registers. Depends on bpm_pkg and bpm_div.
module bpm_datapath
    import bpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output ctrl_status_t          status,
    input  in_item_t              in_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output out_item_t             out_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEB_DOWN,
        PH_PRESSED,
        PH_DEB_UP
    } phase_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Configuration
    logic [15:0] debounce_time_reg;
    logic [15:0] short_limit_reg;
    logic [15:0] indicator_time_reg;
    logic [15:0] blink_half_time_reg;
    logic [4:0]  blink_steps_short_reg;
    logic [4:0]  blink_steps_long_reg;

    // Block state
    phase_t      phase_reg, phase_next;
    logic [31:0] deb_begin_reg, deb_begin_next;
    logic [31:0] press_begin_reg, press_begin_next;
    logic [31:0] press_dur_reg, press_dur_next;
    logic        green_reg, green_next;
    logic [31:0] green_since_reg, green_since_next;
    logic        red_reg, red_next;
    logic [31:0] red_since_reg, red_since_next;
    logic [4:0]  blink_left_reg, blink_left_next;
    logic [31:0] blink_since_reg, blink_since_next;
    logic        yellow_reg, yellow_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] short_reg, short_next;
    logic [15:0] long_reg, long_next;
    logic [31:0] sum_reg, sum_next;

    // Item registers
    in_item_t    in_reg;
    out_item_t   result_reg;
    out_item_t   out_reg;
    out_item_t   sample_result;
    out_item_t   report_result;

    logic        done_v;
    logic        is_short_v;
    logic        div_done;
    logic [31:0] div_quot;

    always_comb
    begin
        logic [31:0] now;
        logic        low;
        logic        deb_ok;
        logic [31:0] blink_elapsed;
        logic [32:0] sum_wide;

        now    = in_reg.now_ms;
        low    = in_reg.button_low;
        deb_ok = (now - deb_begin_reg) >= {16'd0, debounce_time_reg};

        phase_next       = phase_reg;
        deb_begin_next   = deb_begin_reg;
        press_begin_next = press_begin_reg;
        press_dur_next   = press_dur_reg;
        done_v           = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (low)
                begin
                    deb_begin_next = now;
                    phase_next     = PH_DEB_DOWN;
                end
            end
            PH_DEB_DOWN:
            begin
                if (!low)
                begin
                    phase_next = PH_IDLE;
                end
                else if (deb_ok)
                begin
                    press_begin_next = now;
                    phase_next       = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                // The duration is taken at every release edge; after a bounce back, the next release replaces it.
                if (!low)
                begin
                    press_dur_next = now - press_begin_reg;
                    deb_begin_next = now;
                    phase_next     = PH_DEB_UP;
                end
            end
            PH_DEB_UP:
            begin
                if (low)
                begin
                    phase_next = PH_PRESSED;
                end
                else if (deb_ok)
                begin
                    done_v     = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        is_short_v = press_dur_reg < {16'd0, short_limit_reg};

        // A freshly lit indicator has zero elapsed time, so it only stays
        // lit when the hold time is nonzero.
        green_since_next = green_since_reg;
        red_since_next   = red_since_reg;
        if (done_v && is_short_v)
        begin
            green_next       = indicator_time_reg != 16'd0;
            green_since_next = now;
        end
        else
        begin
            green_next = green_reg &&
                !((now - green_since_reg) >= {16'd0, indicator_time_reg});
        end
        if (done_v && !is_short_v)
        begin
            red_next       = indicator_time_reg != 16'd0;
            red_since_next = now;
        end
        else
        begin
            red_next = red_reg &&
                !((now - red_since_reg) >= {16'd0, indicator_time_reg});
        end

        total_next = total_reg;
        short_next = short_reg;
        long_next  = long_reg;
        sum_next   = sum_reg;
        sum_wide   = {1'b0, sum_reg} + {1'b0, press_dur_reg};

        blink_left_next  = blink_left_reg;
        blink_since_next = blink_since_reg;
        yellow_next      = yellow_reg;
        blink_elapsed    = now - blink_since_reg;

        if (done_v)
        begin
            total_next = sat_inc16(total_reg);
            sum_next   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
            if (is_short_v)
            begin
                short_next      = sat_inc16(short_reg);
                blink_left_next = blink_steps_short_reg;
            end
            else
            begin
                long_next       = sat_inc16(long_reg);
                blink_left_next = blink_steps_long_reg;
            end
            yellow_next      = blink_left_next != 5'd0;
            blink_since_next = now;
            blink_elapsed    = '0;
        end

        if (blink_left_next != 5'd0 && blink_elapsed >= {16'd0, blink_half_time_reg})
        begin
            yellow_next      = !yellow_next;
            blink_since_next = now;
            blink_left_next  = blink_left_next - 5'd1;
            if (blink_left_next == 5'd0)
            begin
                yellow_next = 1'b0;
            end
        end

        sample_result                = '0;
        sample_result.is_report      = 1'b0;
        sample_result.green_on       = green_next;
        sample_result.red_on         = red_next;
        sample_result.yellow_on      = yellow_next;
        sample_result.press_done     = done_v;
        sample_result.press_time     = done_v ? press_dur_reg : 32'd0;
        sample_result.press_is_short = done_v && is_short_v;
        sample_result.total_count    = total_next;
        sample_result.short_count    = short_next;
        sample_result.long_count     = long_next;
        sample_result.average_time   = 32'd0;
    end

    // A report carries the current indicator levels and the counts before they clear;
    // the average is filled in once the divider finishes.
    always_comb
    begin
        report_result             = '0;
        report_result.is_report   = 1'b1;
        report_result.green_on    = green_reg;
        report_result.red_on      = red_reg;
        report_result.yellow_on   = yellow_reg;
        report_result.total_count = total_reg;
        report_result.short_count = short_reg;
        report_result.long_count  = long_reg;
    end

    bpm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.exec_report),
        .dividend (sum_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg     <= 16'd50;
            short_limit_reg       <= 16'd500;
            indicator_time_reg    <= 16'd1500;
            blink_half_time_reg   <= 16'd100;
            blink_steps_short_reg <= 5'd10;
            blink_steps_long_reg  <= 5'd20;
            phase_reg             <= PH_IDLE;
            deb_begin_reg         <= '0;
            press_begin_reg       <= '0;
            press_dur_reg         <= '0;
            green_reg             <= 1'b0;
            green_since_reg       <= '0;
            red_reg               <= 1'b0;
            red_since_reg         <= '0;
            blink_left_reg        <= '0;
            blink_since_reg       <= '0;
            yellow_reg            <= 1'b0;
            total_reg             <= '0;
            short_reg             <= '0;
            long_reg              <= '0;
            sum_reg               <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEBOUNCE_TIME:     debounce_time_reg     <= cfg_data;
                    CFG_SHORT_LIMIT:       short_limit_reg       <= cfg_data;
                    CFG_INDICATOR_TIME:    indicator_time_reg    <= cfg_data;
                    CFG_BLINK_HALF_TIME:   blink_half_time_reg   <= cfg_data;
                    CFG_BLINK_STEPS_SHORT: blink_steps_short_reg <= cfg_data[4:0];
                    CFG_BLINK_STEPS_LONG:  blink_steps_long_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.exec_sample)
            begin
                phase_reg       <= phase_next;
                deb_begin_reg   <= deb_begin_next;
                press_begin_reg <= press_begin_next;
                press_dur_reg   <= press_dur_next;
                green_reg       <= green_next;
                green_since_reg <= green_since_next;
                red_reg         <= red_next;
                red_since_reg   <= red_since_next;
                blink_left_reg  <= blink_left_next;
                blink_since_reg <= blink_since_next;
                yellow_reg      <= yellow_next;
                total_reg       <= total_next;
                short_reg       <= short_next;
                long_reg        <= long_next;
                sum_reg         <= sum_next;
            end
            else if (cmd.exec_report)
            begin
                total_reg <= '0;
                short_reg <= '0;
                long_reg  <= '0;
                sum_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.exec_sample)
        begin
            result_reg <= sample_result;
        end
        else if (cmd.exec_report)
        begin
            result_reg <= report_result;
        end
        else if (cmd.store_avg)
        begin
            result_reg.average_time <= (result_reg.total_count == 16'd0) ? 32'd0 : div_quot;
        end
        if (cmd.emit)
        begin
            out_reg <= result_reg;
        end
    end

    assign status.req_type = in_reg.req_type;
    assign status.div_done = div_done;
    assign out_data        = out_reg;

endmodule

>>> hw/rtl/bpm_ctrl.sv
// Controller of the button press monitor: sequences accept, execute, divide and emit.
// Depends on bpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpm_ctrl
    import bpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.load_in     = (state_reg == ST_IDLE) && in_valid;
        cmd.exec_sample = (state_reg == ST_EXEC) && (status.req_type == REQ_SAMPLE);
        cmd.exec_report = (state_reg == ST_EXEC) && (status.req_type == REQ_REPORT);
        cmd.store_avg   = (state_reg == ST_DIV) && status.div_done;
        cmd.emit        = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= (status.req_type == REQ_REPORT) ? ST_DIV : ST_EMIT;
                end
                ST_DIV:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (cmd.emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `BPM_ASSERT(a_one_item, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
    `BPM_ASSERT_NEVER(a_emit_overwrite, clk, rst_n, cmd.emit && out_valid_reg && !out_ready, "result overwritten before it was taken")
    `BPM_ASSERT(a_div_done_waited, clk, rst_n, status.div_done |-> (state_reg == ST_DIV), "divider finished while controller not waiting")

endmodule
